@@ sv/itsv_pkg.sv @@
package itsv_pkg;

	// field widths of the parsed timestamp
	localparam int YEAR_W  = 14;
	localparam int FIELD_W = 7;

	// fixed characters of the form YYYY-MM-DDTHH:MM:SSZ
	localparam logic [7:0] CH_DASH  = 8'h2D;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_T     = 8'h54;
	localparam logic [7:0] CH_Z     = 8'h5A;

	// parsed fields of one timestamp
	typedef struct packed {
		logic [YEAR_W-1:0]  year;
		logic [FIELD_W-1:0] month;
		logic [FIELD_W-1:0] day;
		logic [FIELD_W-1:0] hour;
		logic [FIELD_W-1:0] minute;
		logic [FIELD_W-1:0] second;
	} itsv_fields_t;

endpackage

@@ sv/itsv_in_if.sv @@
interface itsv_in_if;
	import itsv_pkg::*;

	logic       valid;
	logic       ready;
	logic [7:0] char_code;
	logic       is_final;

	modport source(output valid, char_code, is_final, input ready);
	modport sink(input valid, char_code, is_final, output ready);

endinterface

@@ sv/itsv_out_if.sv @@
interface itsv_out_if;
	import itsv_pkg::*;

	logic               valid;
	logic               ready;
	logic               valid_res;
	logic [YEAR_W-1:0]  year_value;
	logic [FIELD_W-1:0] month_value;
	logic [FIELD_W-1:0] day_value;
	logic [FIELD_W-1:0] hour_value;
	logic [FIELD_W-1:0] minute_value;
	logic [FIELD_W-1:0] second_value;

	modport source(output valid, valid_res, year_value, month_value, day_value, hour_value,
		minute_value, second_value, input ready);
	modport sink(input valid, valid_res, year_value, month_value, day_value, hour_value,
		minute_value, second_value, output ready);

endinterface

@@ sv/itsv_date_check.sv @@
module itsv_date_check (
	input  itsv_pkg::itsv_fields_t  fields,
	input  logic [itsv_pkg::FIELD_W-1:0] year_hi,
	input  logic [itsv_pkg::FIELD_W-1:0] year_lo,
	output logic                    date_ok
);
	import itsv_pkg::*;

	localparam logic [YEAR_W-1:0] YEAR_MIN = YEAR_W'(1000);
	localparam logic [YEAR_W-1:0] YEAR_MAX = YEAR_W'(9999);

	logic              leap;
	logic [FIELD_W-1:0] day_limit;
	logic              year_ok;
	logic              month_ok;
	logic              time_ok;

	// gregorian leap test from the two low digits and the century digits
	assign leap = (year_lo != '0) ? (year_lo[1:0] == 2'b00) : (year_hi[1:0] == 2'b00);

	// length of the month
	always_comb begin
		unique case (fields.month) inside
			FIELD_W'(2):                                     day_limit = leap ? FIELD_W'(29)
			                                                                   : FIELD_W'(28);
			FIELD_W'(4), FIELD_W'(6), FIELD_W'(9), FIELD_W'(11): day_limit = FIELD_W'(30);
			default:                                         day_limit = FIELD_W'(31);
		endcase
	end

	// range checks
	assign year_ok  = (fields.year >= YEAR_MIN) && (fields.year <= YEAR_MAX);
	assign month_ok = (fields.month >= FIELD_W'(1)) && (fields.month <= FIELD_W'(12));
	assign time_ok  = (fields.hour <= FIELD_W'(23)) && (fields.minute <= FIELD_W'(59))
		&& (fields.second <= FIELD_W'(59));
	assign date_ok  = year_ok && month_ok && time_ok && (fields.day >= FIELD_W'(1))
		&& (fields.day <= day_limit);

endmodule

@@ sv/iso8601_timestamp_validator_top.sv @@
// Checks a timestamp string of the form YYYY-MM-DDTHH:MM:SSZ that arrives one character per
// word on the chars channel, the last character marked by is_final. One result word leaves on
// the results channel for every final character: valid_res and the parsed fields, all fields
// zero when the string is not a valid UTC timestamp (wrong length, misplaced character, field
// out of range, or day past the end of its month with Gregorian leap years). The block takes
// one character every clock; a character passes an input register and the checking logic, and a
// result word is held in the result register until it is taken. Input stalls only when a final
// character waits for the result register while the previous result is still not taken.
module iso8601_timestamp_validator_top (
	input  logic  clk,
	input  logic  arst_n,
	itsv_in_if.sink    chars,
	itsv_out_if.source results
);
	import itsv_pkg::*;

	localparam logic [4:0] LAST_POS = 5'd19;
	localparam logic [4:0] POS_MAX  = 5'd31;

	typedef enum logic [2:0] {
		FS_NONE, FS_YEAR_HI, FS_YEAR_LO, FS_MONTH, FS_DAY, FS_HOUR, FS_MINUTE, FS_SECOND
	} field_sel_t;

	// input register
	logic       valid_s1;
	logic [7:0] char_s1;
	logic       final_s1;

	// parser state
	logic [4:0]         pos_q;
	logic               fmt_ok_q;
	itsv_fields_t       acc_q;
	logic [FIELD_W-1:0] year_hi_q;
	logic [FIELD_W-1:0] year_lo_q;

	// result register
	logic               out_valid_q;
	logic               res_ok_q;
	itsv_fields_t       res_q;

	logic       out_free;
	logic       s1_go;
	field_sel_t fsel;
	logic       is_sep;
	logic [7:0] sep_char;
	logic       is_digit;
	logic [3:0] digit;
	logic       char_bad;
	logic       date_ok;
	logic       str_ok;

	function automatic logic [FIELD_W-1:0] acc7(input logic [FIELD_W-1:0] a,
		input logic [3:0] d);
		logic [FIELD_W+3:0] t;
		t = {1'b0, a, 3'b000} + {3'b000, a, 1'b0} + {{FIELD_W{1'b0}}, d};
		return t[FIELD_W-1:0];
	endfunction

	function automatic logic [YEAR_W-1:0] acc14(input logic [YEAR_W-1:0] a,
		input logic [3:0] d);
		logic [YEAR_W+3:0] t;
		t = {1'b0, a, 3'b000} + {3'b000, a, 1'b0} + {{YEAR_W{1'b0}}, d};
		return t[YEAR_W-1:0];
	endfunction

	// handshake: a non-final word always moves on, a final one needs the result register
	assign out_free    = !out_valid_q || results.ready;
	assign s1_go       = valid_s1 && (!final_s1 || out_free);
	assign chars.ready = !valid_s1 || s1_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (chars.ready) begin
			valid_s1 <= chars.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (chars.ready && chars.valid) begin
			char_s1  <= chars.char_code;
			final_s1 <= chars.is_final;
		end
	end

	// position decoder
	always_comb begin
		fsel     = FS_NONE;
		is_sep   = 1'b0;
		sep_char = CH_DASH;
		unique case (pos_q) inside
			5'd0, 5'd1:   fsel = FS_YEAR_HI;
			5'd2, 5'd3:   fsel = FS_YEAR_LO;
			5'd4, 5'd7:   is_sep = 1'b1;
			5'd5, 5'd6:   fsel = FS_MONTH;
			5'd8, 5'd9:   fsel = FS_DAY;
			5'd10: begin
				is_sep   = 1'b1;
				sep_char = CH_T;
			end
			5'd11, 5'd12: fsel = FS_HOUR;
			5'd13, 5'd16: begin
				is_sep   = 1'b1;
				sep_char = CH_COLON;
			end
			5'd14, 5'd15: fsel = FS_MINUTE;
			5'd17, 5'd18: fsel = FS_SECOND;
			5'd19: begin
				is_sep   = 1'b1;
				sep_char = CH_Z;
			end
			default:      fsel = FS_NONE;
		endcase
	end

	// character class
	assign is_digit = (char_s1[7:4] == 4'h3) && (char_s1[3:0] <= 4'd9);
	assign digit    = char_s1[3:0];
	assign char_bad = is_sep ? (char_s1 != sep_char)
		: ((fsel == FS_NONE) || !is_digit);

	// field checks on the collected values; no field changes at the last position
	itsv_date_check u_date_check (
		.fields  (acc_q),
		.year_hi (year_hi_q),
		.year_lo (year_lo_q),
		.date_ok (date_ok)
	);

	assign str_ok = fmt_ok_q && !char_bad && (pos_q == LAST_POS) && date_ok;

	// parser state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			fmt_ok_q  <= 1'b1;
			acc_q     <= '0;
			year_hi_q <= '0;
			year_lo_q <= '0;
		end else if (s1_go) begin
			if (final_s1) begin
				pos_q     <= '0;
				fmt_ok_q  <= 1'b1;
				acc_q     <= '0;
				year_hi_q <= '0;
				year_lo_q <= '0;
			end else begin
				if (pos_q != POS_MAX) begin
					pos_q <= pos_q + 5'd1;
				end
				if (char_bad) begin
					fmt_ok_q <= 1'b0;
				end else begin
					case (fsel)
						FS_YEAR_HI: begin
							acc_q.year <= acc14(acc_q.year, digit);
							year_hi_q  <= acc7(year_hi_q, digit);
						end
						FS_YEAR_LO: begin
							acc_q.year <= acc14(acc_q.year, digit);
							year_lo_q  <= acc7(year_lo_q, digit);
						end
						FS_MONTH:  acc_q.month  <= acc7(acc_q.month, digit);
						FS_DAY:    acc_q.day    <= acc7(acc_q.day, digit);
						FS_HOUR:   acc_q.hour   <= acc7(acc_q.hour, digit);
						FS_MINUTE: acc_q.minute <= acc7(acc_q.minute, digit);
						FS_SECOND: acc_q.second <= acc7(acc_q.second, digit);
						default:   ;
					endcase
				end
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_go && final_s1) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && final_s1) begin
			res_ok_q <= str_ok;
			res_q    <= str_ok ? acc_q : '0;
		end
	end

	assign results.valid        = out_valid_q;
	assign results.valid_res    = res_ok_q;
	assign results.year_value   = res_q.year;
	assign results.month_value  = res_q.month;
	assign results.day_value    = res_q.day;
	assign results.hour_value   = res_q.hour;
	assign results.minute_value = res_q.minute;
	assign results.second_value = res_q.second;

`ifndef SYNTH
	// a valid result carries a real month and day
	a_valid_fields: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && results.valid_res |-> results.month_value >= FIELD_W'(1)
		&& results.month_value <= FIELD_W'(12) && results.day_value >= FIELD_W'(1)
		&& results.day_value <= FIELD_W'(31))
		else $error("valid result with month or day out of range");

	// an invalid result carries zero fields
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && !results.valid_res |-> res_q == '0)
		else $error("invalid result with nonzero fields");

	// parser restarts after a final character
	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		s1_go && final_s1 |=> pos_q == '0 && fmt_ok_q && acc_q == '0)
		else $error("parser state not cleared after final character");

	// input stalls only behind a final character waiting for the result register
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!chars.ready |-> valid_s1 && final_s1 && out_valid_q && !results.ready)
		else $error("input stalled without a pending result");
`endif

endmodule
